// ===== rtl/pcfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcfa_pkg
// Shared widths, reset values and codes of the partitioned core fit allocator.
// ----------------------------------------------------------------------------
package pcfa_pkg;

    localparam int NUM_CORES_DEF = 4;
    localparam int MAX_TASKS_DEF = 256;

    localparam int LOAD_W    = 16;
    localparam int ID_W      = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [LOAD_W-1:0] CAPACITY_RESET = LOAD_W'(2000);

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_mode_t;

    typedef enum logic {
        OP_PLACE = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_MODE      = 1'b0,
        CFG_CORE_CAPACITY = 1'b1
    } cfg_index_t;

endpackage : pcfa_pkg
`default_nettype wire

// ===== rtl/pcfa_fit_select.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcfa_fit_select
// Per-core fit checks and a pairwise select tree that picks the core for a
// task under first-fit, best-fit or worst-fit; ties go to the lower index.
// ----------------------------------------------------------------------------
module pcfa_fit_select #(
    parameter int NUM_CORES = pcfa_pkg::NUM_CORES_DEF,
    parameter int MAX_TASKS = pcfa_pkg::MAX_TASKS_DEF,
    localparam int CORE_W   = $clog2(NUM_CORES),
    localparam int CNT_W    = $clog2(MAX_TASKS + 1)
) (
    input  wire logic [pcfa_pkg::LOAD_W-1:0] core_load [NUM_CORES],
    input  wire logic [CNT_W-1:0]            core_count [NUM_CORES],
    input  wire logic [pcfa_pkg::LOAD_W-1:0] demand,
    input  wire logic [pcfa_pkg::LOAD_W-1:0] capacity,
    input  wire logic [pcfa_pkg::MODE_W-1:0] fit_mode,
    output logic                             found,
    output logic [CORE_W-1:0]                pick
);
    import pcfa_pkg::*;

    localparam int LEAVES = 1 << CORE_W;

    logic              cand_v  [CORE_W+1][LEAVES];
    logic [LOAD_W-1:0] cand_ld [CORE_W+1][LEAVES];
    logic [CORE_W-1:0] cand_ix [CORE_W+1][LEAVES];

    always_comb
    begin
        logic take_hi;
        for (int i = 0; i < LEAVES; i++)
        begin
            if (i < NUM_CORES)
            begin
                cand_v[0][i]  = (core_count[i] < CNT_W'(MAX_TASKS)) &&
                                (({1'b0, core_load[i]} + {1'b0, demand}) <=
                                 {1'b0, capacity});
                cand_ld[0][i] = core_load[i];
            end
            else
            begin
                cand_v[0][i]  = 1'b0;
                cand_ld[0][i] = '0;
            end
            cand_ix[0][i] = CORE_W'(i);
        end
        for (int l = 1; l <= CORE_W; l++)
        begin
            for (int i = 0; i < LEAVES; i++)
            begin
                if (i < (LEAVES >> l))
                begin
                    // left entry always holds the lower core indices
                    if (!cand_v[l-1][2*i])
                        take_hi = 1'b1;
                    else if (!cand_v[l-1][2*i+1])
                        take_hi = 1'b0;
                    else if (fit_mode == FIT_BEST)
                        take_hi = cand_ld[l-1][2*i+1] > cand_ld[l-1][2*i];
                    else if (fit_mode == FIT_WORST)
                        take_hi = cand_ld[l-1][2*i+1] < cand_ld[l-1][2*i];
                    else
                        take_hi = 1'b0;
                    cand_v[l][i]  = take_hi ? cand_v[l-1][2*i+1]  : cand_v[l-1][2*i];
                    cand_ld[l][i] = take_hi ? cand_ld[l-1][2*i+1] : cand_ld[l-1][2*i];
                    cand_ix[l][i] = take_hi ? cand_ix[l-1][2*i+1] : cand_ix[l-1][2*i];
                end
                else
                begin
                    cand_v[l][i]  = 1'b0;
                    cand_ld[l][i] = '0;
                    cand_ix[l][i] = '0;
                end
            end
        end
    end

    assign found = cand_v[CORE_W][0];
    assign pick  = cand_ix[CORE_W][0];

endmodule : pcfa_fit_select
`default_nettype wire

// ===== rtl/partitioned_core_fit_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// partitioned_core_fit_allocator_core
// Places each task on one of NUM_CORES cores by first/best/worst fit and
// keeps per-core load and task count; a clear op empties every core.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid / in_stall    | op, task_id, demand
//  out      | out_valid / out_stall  | echo_id, accepted, chosen_core,
//           |                        | load_after, tasks_on_core
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; the result is registered on transfer.
// Fit checks and the select tree run in the accept cycle, and the chosen
// core's load and count are written back at that same edge.
// A two-entry output buffer (result register plus skid) keeps input flowing
// while out_stall is high for one cycle; in_stall rises only when both hold.
// Reset clears loads, counts, fit_mode to first-fit and capacity to 2000.
// ----------------------------------------------------------------------------
module partitioned_core_fit_allocator_core #(
    parameter int NUM_CORES = pcfa_pkg::NUM_CORES_DEF,
    parameter int MAX_TASKS = pcfa_pkg::MAX_TASKS_DEF,
    localparam int CORE_W   = $clog2(NUM_CORES),
    localparam int CNT_W    = $clog2(MAX_TASKS + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pcfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pcfa_pkg::CFG_DAT_W-1:0] cfg_data,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           op,
    input  wire logic [pcfa_pkg::ID_W-1:0]      task_id,
    input  wire logic [pcfa_pkg::LOAD_W-1:0]    demand,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [pcfa_pkg::ID_W-1:0]           echo_id,
    output logic                                accepted,
    output logic [CORE_W-1:0]                   chosen_core,
    output logic [pcfa_pkg::LOAD_W-1:0]         load_after,
    output logic [CNT_W-1:0]                    tasks_on_core
);
    import pcfa_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              acc;
        logic [CORE_W-1:0] core;
        logic [LOAD_W-1:0] load;
        logic [CNT_W-1:0]  cnt;
    } result_t;

    logic [MODE_W-1:0] fit_mode_reg;
    logic [LOAD_W-1:0] capacity_reg;
    logic [LOAD_W-1:0] core_load_reg  [NUM_CORES];
    logic [CNT_W-1:0]  core_count_reg [NUM_CORES];
    logic [LOAD_W-1:0] core_load_next  [NUM_CORES];
    logic [CNT_W-1:0]  core_count_next [NUM_CORES];

    logic              out_valid_reg, skid_valid_reg;
    result_t           out_reg, skid_reg, res_next;

    logic              found;
    logic [CORE_W-1:0] pick;
    logic              in_xfer, out_xfer, cfg_xfer, place_ok, all_empty;
    logic [LOAD_W-1:0] new_load;
    logic [CNT_W-1:0]  new_count;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign in_stall  = skid_valid_reg;
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;

    pcfa_fit_select #(
        .NUM_CORES (NUM_CORES),
        .MAX_TASKS (MAX_TASKS)
    ) u_select (
        .core_load  (core_load_reg),
        .core_count (core_count_reg),
        .demand     (demand),
        .capacity   (capacity_reg),
        .fit_mode   (fit_mode_reg),
        .found      (found),
        .pick       (pick)
    );

    assign place_ok  = (op == OP_PLACE) && found;
    assign new_load  = core_load_reg[pick] + demand;
    assign new_count = core_count_reg[pick] + CNT_W'(1);

    always_comb
    begin
        res_next.id   = task_id;
        res_next.acc  = place_ok;
        res_next.core = place_ok ? pick : '0;
        res_next.load = place_ok ? new_load : '0;
        res_next.cnt  = place_ok ? new_count : '0;
        for (int i = 0; i < NUM_CORES; i++)
        begin
            core_load_next[i]  = core_load_reg[i];
            core_count_next[i] = core_count_reg[i];
            if (op == OP_CLEAR)
            begin
                core_load_next[i]  = '0;
                core_count_next[i] = '0;
            end
            else if (place_ok && (pick == CORE_W'(i)))
            begin
                core_load_next[i]  = new_load;
                core_count_next[i] = new_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg   <= FIT_FIRST;
            capacity_reg   <= CAPACITY_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CORES; i++)
            begin
                core_load_reg[i]  <= '0;
                core_count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_xfer)
            begin
                unique case (cfg_index)
                    CFG_FIT_MODE:      fit_mode_reg <= cfg_data[MODE_W-1:0];
                    CFG_CORE_CAPACITY: capacity_reg <= cfg_data[LOAD_W-1:0];
                    default:           ;
                endcase
            end
            if (in_xfer)
            begin
                for (int i = 0; i < NUM_CORES; i++)
                begin
                    core_load_reg[i]  <= core_load_next[i];
                    core_count_reg[i] <= core_count_next[i];
                end
            end
            if (skid_valid_reg)
            begin
                if (out_xfer)
                    skid_valid_reg <= 1'b0;
            end
            else if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
                if (out_valid_reg && !out_xfer)
                    skid_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
                out_reg <= skid_reg;
        end
        else if (in_xfer)
        begin
            if (!out_valid_reg || out_xfer)
                out_reg <= res_next;
            else
                skid_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign echo_id       = out_reg.id;
    assign accepted      = out_reg.acc;
    assign chosen_core   = out_reg.core;
    assign load_after    = out_reg.load;
    assign tasks_on_core = out_reg.cnt;

    always_comb
    begin
        all_empty = 1'b1;
        for (int i = 0; i < NUM_CORES; i++)
            if (core_load_reg[i] != '0 || core_count_reg[i] != '0)
                all_empty = 1'b0;
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in the output register");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && op == OP_CLEAR) |=> all_empty)
        else $error("clear left a core with load or tasks");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.acc) |->
            (out_reg.core == '0 && out_reg.load == '0 && out_reg.cnt == '0))
        else $error("rejected result carries nonzero placement fields");

    a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.acc) |-> (out_reg.cnt != '0))
        else $error("placed task reports an empty core");

endmodule : partitioned_core_fit_allocator_core
`default_nettype wire
